>>> sv/tsc_pkg.sv
`timescale 1ns / 1ps

package tsc_pkg;

   // Field widths
   localparam int TS_W    = 48;
   localparam int TZ_W    = 5;
   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DOM_W   = 5;
   localparam int DOW_W   = 3;
   localparam int WEEK_W  = 6;

   // Adjusted time: two guard bits cover the sign and the carry of the offset add
   localparam int ADJ_W    = TS_W + 2;
   localparam int OFF_MS_W = 27;
   localparam logic [OFF_MS_W-1:0] MS_PER_HOUR = 27'd3600000;
   localparam logic [TZ_W-1:0] TZ_RESET = 5'd8;

   // First millisecond past 9999-12-31 23:59:59.999
   localparam logic [TS_W-1:0] ADJ_LIMIT_MS = 48'd253402300800000;

   // 86400000 = 2^10 * 84375: shift off the power of two, divide by the odd part
   localparam int DAY_SHIFT = 10;
   localparam int DIV_W     = TS_W - DAY_SHIFT;
   localparam logic [DIV_W-1:0] DAY_ODD_DIV = 38'd84375;
   localparam int DAYS_W     = 22;
   localparam int DIV_STAGES = DAYS_W / 2;

   // Civil conversion pipeline
   localparam int CIV_STAGES = 9;
   localparam int DOY_W      = 9;

   localparam int DAYS_PER_WEEK = 7;
   localparam int THURSDAY_ISO  = 4;

   typedef struct packed {
      logic             valid;
      logic             range_err;
      logic [DOW_W-1:0] dow;
   } ctrl_type;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DOM_W-1:0]   day;
      logic [DOY_W-1:0]   ordinal;
   } civil_type;

   // Weekday, 1 Sunday .. 7 Saturday, from days since epoch mod 7
   function automatic logic [DOW_W-1:0] dow_of_rem(input logic [2:0] r);
      logic [DOW_W-1:0] d;
      case (r)
         3'd0:    d = 3'd5;
         3'd1:    d = 3'd6;
         3'd2:    d = 3'd7;
         3'd3:    d = 3'd1;
         3'd4:    d = 3'd2;
         3'd5:    d = 3'd3;
         3'd6:    d = 3'd4;
         default: d = 3'd0;
      endcase
      return d;
   endfunction

   // ISO weekday, 1 Monday .. 7 Sunday, from days since epoch mod 7
   function automatic logic [DOW_W-1:0] iso_of_rem(input logic [2:0] r);
      logic [DOW_W-1:0] d;
      case (r)
         3'd0:    d = 3'd4;
         3'd1:    d = 3'd5;
         3'd2:    d = 3'd6;
         3'd3:    d = 3'd7;
         3'd4:    d = 3'd1;
         3'd5:    d = 3'd2;
         3'd6:    d = 3'd3;
         default: d = 3'd0;
      endcase
      return d;
   endfunction

endpackage

>>> sv/tsc_day_div.sv
`timescale 1ns / 1ps

// Radix-4 restoring divide of the shifted time by the odd part of a day.
module tsc_day_div (
   input  logic                        clock,
   input  logic [tsc_pkg::DIV_W-1:0]   dividend,
   output logic [tsc_pkg::DAYS_W-1:0]  quotient
);
   import tsc_pkg::*;

   logic [DIV_W-1:0]  rem_ff [DIV_STAGES-1];
   logic [DAYS_W-1:0] quo_ff [DIV_STAGES];

   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
      localparam int SH = DAYS_W - 2 - 2 * j;
      localparam logic [DIV_W+1:0] D1 = (DIV_W + 2)'(DAY_ODD_DIV) << SH;
      localparam logic [DIV_W+1:0] D2 = D1 << 1;
      localparam logic [DIV_W+1:0] D3 = D1 + D2;

      logic [DIV_W-1:0]  rem_cur;
      logic [DAYS_W-1:0] quo_cur;
      logic [DIV_W+1:0]  wide;
      logic [DIV_W+1:0]  sub;
      logic [1:0]        digit;
      logic [DIV_W-1:0]  rem_in;
      logic [DAYS_W-1:0] quo_in;

      if (j == 0) begin : g_first
         assign rem_cur = dividend;
         assign quo_cur = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[j-1];
         assign quo_cur = quo_ff[j-1];
      end

      always_comb begin
         wide = {2'b00, rem_cur};
         if (wide >= D3) begin
            digit = 2'd3;
            sub   = D3;
         end else if (wide >= D2) begin
            digit = 2'd2;
            sub   = D2;
         end else if (wide >= D1) begin
            digit = 2'd1;
            sub   = D1;
         end else begin
            digit = 2'd0;
            sub   = '0;
         end
         rem_in = DIV_W'(wide - sub);
         quo_in = {quo_cur[DAYS_W-3:0], digit};
      end

      always_ff @(posedge clock) begin
         quo_ff[j] <= quo_in;
      end

      if (j < DIV_STAGES - 1) begin : g_keep
         always_ff @(posedge clock) begin
            rem_ff[j] <= rem_in;
         end
      end
   end

   assign quotient = quo_ff[DIV_STAGES-1];

endmodule

>>> sv/tsc_civil.sv
`timescale 1ns / 1ps

// Days since epoch to Gregorian year, month, day and zero-based day of year.
module tsc_civil (
   input  logic                       clock,
   input  logic [tsc_pkg::DAYS_W-1:0] day_num,
   output tsc_pkg::civil_type         civil
);
   import tsc_pkg::*;

   localparam int Z_W   = DAYS_W;
   localparam int ERA_W = 5;
   localparam int DOE_W = 18;
   localparam int YOE_W = 9;
   localparam int MP_W  = 4;
   localparam int MPN_W = DOY_W + 2;

   localparam logic [Z_W-1:0] EPOCH_BIAS = Z_W'(719468);
   localparam longint unsigned DAYS_PER_ERA = 146097;
   localparam longint unsigned DAYS_4Y      = 1460;
   localparam longint unsigned DAYS_100Y    = 36524;
   localparam logic [DOE_W-1:0] LAST_DOE    = DOE_W'(146096);
   localparam int DAYS_PER_YEAR = 365;
   localparam int YEARS_PER_ERA = 400;
   localparam int MAR_TO_JAN    = 306;
   localparam int JAN_TO_MAR    = 59;

   // Reciprocal constants: ceil(2^K / d), K chosen so the floor is exact
   localparam int ERA_K  = 40;
   localparam longint unsigned ERA_MUL =
      ((64'd1 << ERA_K) + DAYS_PER_ERA - 64'd1) / DAYS_PER_ERA;
   localparam int ERA_MUL_W = $clog2(ERA_MUL + 1);
   localparam int ERA_P_W   = Z_W + ERA_MUL_W;

   localparam int C4_K = 29;
   localparam longint unsigned C4_MUL = ((64'd1 << C4_K) + DAYS_4Y - 64'd1) / DAYS_4Y;
   localparam int C4_MUL_W = $clog2(C4_MUL + 1);
   localparam int C4_P_W   = DOE_W + C4_MUL_W;

   localparam int C100_K = 34;
   localparam longint unsigned C100_MUL =
      ((64'd1 << C100_K) + DAYS_100Y - 64'd1) / DAYS_100Y;
   localparam int C100_MUL_W = $clog2(C100_MUL + 1);
   localparam int C100_P_W   = DOE_W + C100_MUL_W;

   localparam int Y_K = 27;
   localparam longint unsigned Y_MUL = ((64'd1 << Y_K) + 64'd364) / 64'd365;
   localparam int Y_MUL_W = $clog2(Y_MUL + 1);
   localparam int Y_P_W   = DOE_W + Y_MUL_W;

   localparam int MP_K = 19;
   localparam longint unsigned MP_MUL = ((64'd1 << MP_K) + 64'd152) / 64'd153;
   localparam int MP_MUL_W = $clog2(MP_MUL + 1);
   localparam int MP_P_W   = MPN_W + MP_MUL_W;

   // First day of each March-based month
   function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
      logic [DOY_W-1:0] s;
      case (mp)
         4'd0:    s = 9'd0;
         4'd1:    s = 9'd31;
         4'd2:    s = 9'd61;
         4'd3:    s = 9'd92;
         4'd4:    s = 9'd122;
         4'd5:    s = 9'd153;
         4'd6:    s = 9'd184;
         4'd7:    s = 9'd214;
         4'd8:    s = 9'd245;
         4'd9:    s = 9'd275;
         4'd10:   s = 9'd306;
         4'd11:   s = 9'd337;
         default: s = 9'd0;
      endcase
      return s;
   endfunction

   function automatic logic yoe7_in_range(input logic [YOE_W-1:0] y,
                                          input logic [YOE_W-1:0] lim);
      return y >= lim;
   endfunction

   logic [Z_W-1:0]   z_ff, z2_ff;
   logic [ERA_W-1:0] era2_ff, era3_ff, era4_ff, era5_ff, era6_ff, era7_ff, era8_ff;
   logic [DOE_W-1:0] doe3_ff, doe4_ff, doe5_ff, doe6_ff;
   logic [6:0]       q4y_ff;
   logic [2:0]       q100y_ff;
   logic             full_ff;
   logic [DOE_W-1:0] t5_ff;
   logic [YOE_W-1:0] yoe6_ff, yoe7_ff, yoe8_ff;
   logic [DOY_W-1:0] doy7_ff, doy8_ff;
   logic [MP_W-1:0]  mp8_ff;
   civil_type        civil_ff;

   logic [ERA_P_W-1:0]  era_prod;
   logic [Z_W-1:0]      doe_full;
   logic [DOE_W-1:0]    doe3_in;
   logic [C4_P_W-1:0]   q4y_prod;
   logic [C100_P_W-1:0] q100y_prod;
   logic [DOE_W-1:0]    t5_in;
   logic [Y_P_W-1:0]    yoe_prod;
   logic [1:0]          cent;
   logic [DOE_W-1:0]    year_base;
   logic [DOY_W-1:0]    doy7_in;
   logic [MPN_W-1:0]    mp_num;
   logic [MP_P_W-1:0]   mp_prod;
   logic                jan_feb;
   logic                leap;
   civil_type           civil_in;

   // era = z / 146097
   assign era_prod = ERA_P_W'(z_ff) * ERA_P_W'(ERA_MUL);

   // doe = z - era * 146097
   assign doe_full = z2_ff - Z_W'(era2_ff) * Z_W'(DAYS_PER_ERA);
   assign doe3_in  = doe_full[DOE_W-1:0];

   // Leap-cycle corrections
   assign q4y_prod   = C4_P_W'(doe3_ff) * C4_P_W'(C4_MUL);
   assign q100y_prod = C100_P_W'(doe3_ff) * C100_P_W'(C100_MUL);

   assign t5_in = doe4_ff - DOE_W'(q4y_ff) + DOE_W'(q100y_ff) - DOE_W'(full_ff);

   // yoe = t / 365
   assign yoe_prod = Y_P_W'(t5_ff) * Y_P_W'(Y_MUL);

   always_comb begin
      if (yoe7_in_range(yoe6_ff, 9'd300)) begin
         cent = 2'd3;
      end else if (yoe7_in_range(yoe6_ff, 9'd200)) begin
         cent = 2'd2;
      end else if (yoe7_in_range(yoe6_ff, 9'd100)) begin
         cent = 2'd1;
      end else begin
         cent = 2'd0;
      end
      year_base = DOE_W'(yoe6_ff) * DOE_W'(DAYS_PER_YEAR) + DOE_W'(yoe6_ff >> 2)
                  - DOE_W'(cent);
      doy7_in   = DOY_W'(doe6_ff - year_base);
   end

   // mp = (5 * doy + 2) / 153
   assign mp_num  = MPN_W'(doy7_ff) * MPN_W'(5) + MPN_W'(2);
   assign mp_prod = MP_P_W'(mp_num) * MP_P_W'(MP_MUL);

   always_comb begin
      jan_feb = mp8_ff >= MP_W'(10);
      leap    = (yoe8_ff[1:0] == 2'b00) && (yoe8_ff != YOE_W'(100))
                && (yoe8_ff != YOE_W'(200)) && (yoe8_ff != YOE_W'(300));
      civil_in.day   = DOM_W'(doy8_ff - month_start(mp8_ff) + DOY_W'(1));
      civil_in.month = jan_feb ? MONTH_W'(mp8_ff - MP_W'(9)) : MONTH_W'(mp8_ff + MP_W'(3));
      civil_in.year  = YEAR_W'(yoe8_ff) + YEAR_W'(era8_ff) * YEAR_W'(YEARS_PER_ERA)
                       + YEAR_W'(jan_feb);
      civil_in.ordinal = jan_feb ? DOY_W'(doy8_ff - DOY_W'(MAR_TO_JAN))
                                 : DOY_W'(doy8_ff + DOY_W'(JAN_TO_MAR) + DOY_W'(leap));
   end

   always_ff @(posedge clock) begin
      z_ff     <= day_num + EPOCH_BIAS;
      z2_ff    <= z_ff;
      era2_ff  <= era_prod[ERA_K +: ERA_W];
      doe3_ff  <= doe3_in;
      era3_ff  <= era2_ff;
      doe4_ff  <= doe3_ff;
      era4_ff  <= era3_ff;
      q4y_ff   <= q4y_prod[C4_K +: 7];
      q100y_ff <= q100y_prod[C100_K +: 3];
      full_ff  <= doe3_ff == LAST_DOE;
      t5_ff    <= t5_in;
      doe5_ff  <= doe4_ff;
      era5_ff  <= era4_ff;
      yoe6_ff  <= yoe_prod[Y_K +: YOE_W];
      doe6_ff  <= doe5_ff;
      era6_ff  <= era5_ff;
      doy7_ff  <= doy7_in;
      yoe7_ff  <= yoe6_ff;
      era7_ff  <= era6_ff;
      mp8_ff   <= mp_prod[MP_K +: MP_W];
      doy8_ff  <= doy7_ff;
      yoe8_ff  <= yoe7_ff;
      era8_ff  <= era7_ff;
      civil_ff <= civil_in;
   end

   assign civil = civil_ff;

endmodule

>>> sv/timestamp_to_calendar_fields.sv
// Millisecond timestamp to calendar fields (year, month, day, weekday, ISO week).
// Throughput: one transaction per cycle; busy is always low and the receiver cannot stall.
// The depth is set by the 11-stage radix-4 day divider and the 9-stage civil pipeline.
// Reset (synchronous, active high) clears all valid bits and sets the offset to +8 hours.
`timescale 1ns / 1ps

module timestamp_to_calendar_fields (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [tsc_pkg::TS_W-1:0]          req_timestamp_ms,
   input  logic                              csr_wr_en,
   input  logic signed [tsc_pkg::TZ_W-1:0]   csr_wr_data,
   output logic                              rsp_valid,
   output logic [tsc_pkg::YEAR_W-1:0]        rsp_year_value,
   output logic [tsc_pkg::MONTH_W-1:0]       rsp_month_value,
   output logic [tsc_pkg::DOM_W-1:0]         rsp_day_of_month,
   output logic [tsc_pkg::DOW_W-1:0]         rsp_weekday,
   output logic [tsc_pkg::WEEK_W-1:0]        rsp_iso_week,
   output logic                              rsp_range_error
);
   import tsc_pkg::*;

   // days / 7 by reciprocal
   localparam int Q7_K = 25;
   localparam longint unsigned Q7_MUL = ((64'd1 << Q7_K) + 64'd6) / 64'd7;
   localparam int Q7_MUL_W = $clog2(Q7_MUL + 1);
   localparam int Q7_P_W   = DAYS_W + Q7_MUL_W;
   localparam int Q7_W     = DAYS_W - 2;

   // day-of-year / 7 by reciprocal, for the week number
   localparam int WK_K = 12;
   localparam longint unsigned WK_MUL = ((64'd1 << WK_K) + 64'd6) / 64'd7;
   localparam int WK_MUL_W = $clog2(WK_MUL + 1);
   localparam int WK_P_W   = DOY_W + WK_MUL_W;

   logic signed [TZ_W-1:0] tz_ff;

   logic                   accept;
   logic [OFF_MS_W-1:0]    off_ms;
   logic [ADJ_W-1:0]       adj_in;
   logic [ADJ_W-1:0]       adj_ff;
   logic                   v1_ff;

   logic                   too_early;
   logic                   too_late;
   logic [DIV_W-1:0]       x_ff;
   ctrl_type               ctrl2_ff;

   logic [DAYS_W-1:0]      days_q;
   ctrl_type               div_ctrl_ff [DIV_STAGES];

   logic [Q7_P_W-1:0]      q7_prod;
   logic [DAYS_W-1:0]      days3_ff;
   logic [Q7_W-1:0]        q7_ff;
   ctrl_type               ctrl3_ff;

   logic [DAYS_W-1:0]      rem7_full;
   logic [2:0]             rem7;
   logic [DOW_W-1:0]       iso_dow;
   logic [DAYS_W-1:0]      thu_in;
   ctrl_type               ctrl4_in;
   logic [DAYS_W-1:0]      days4_ff;
   logic [DAYS_W-1:0]      thu4_ff;
   ctrl_type               ctrl4_ff;

   civil_type              civ_date;
   civil_type              civ_thu;
   ctrl_type               civ_ctrl_ff [CIV_STAGES];
   ctrl_type               ctrl_out;

   logic [WK_P_W-1:0]      wk_prod;
   logic [WEEK_W-1:0]      week_in;

   logic                   rsp_valid_ff;
   logic [YEAR_W-1:0]      year_ff;
   logic [MONTH_W-1:0]     month_ff;
   logic [DOM_W-1:0]       dom_ff;
   logic [DOW_W-1:0]       dow_ff;
   logic [WEEK_W-1:0]      week_ff;
   logic                   range_err_ff;

   // No back-pressure: every stage advances each cycle
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Offset register: the user must write it only while no transaction is in flight; the block does not enforce this
   always_ff @(posedge clock) begin
      if (reset) begin
         tz_ff <= TZ_RESET;
      end else if (csr_wr_en) begin
         tz_ff <= csr_wr_data;
      end
   end

   // Stage 1: add the offset in milliseconds (modular product keeps the sign)
   assign off_ms = {{(OFF_MS_W - TZ_W){tz_ff[TZ_W-1]}}, tz_ff} * MS_PER_HOUR;
   assign adj_in = ADJ_W'(req_timestamp_ms)
                   + {{(ADJ_W - OFF_MS_W){off_ms[OFF_MS_W-1]}}, off_ms};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
      end
      adj_ff <= adj_in;
   end

   // Stage 2: range check, drop the 2^10 factor of a day in milliseconds
   assign too_early = adj_ff[ADJ_W-1];
   assign too_late  = adj_ff[ADJ_W-2:0] >= (ADJ_W - 1)'(ADJ_LIMIT_MS);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl2_ff <= '0;
      end else begin
         ctrl2_ff.valid     <= v1_ff;
         ctrl2_ff.range_err <= too_early || too_late;
         ctrl2_ff.dow       <= '0;
      end
      x_ff <= adj_ff[TS_W-1:DAY_SHIFT];
   end

   // Whole days since epoch
   tsc_day_div u_day_div (
      .clock    (clock),
      .dividend (x_ff),
      .quotient (days_q)
   );

   // Hold control alongside the divider stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            div_ctrl_ff[k] <= '0;
         end
      end else begin
         div_ctrl_ff[0] <= ctrl2_ff;
         for (int k = 1; k < DIV_STAGES; k++) begin
            div_ctrl_ff[k] <= div_ctrl_ff[k-1];
         end
      end
   end

   // Stage 3: days / 7
   assign q7_prod = Q7_P_W'(days_q) * Q7_P_W'(Q7_MUL);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl3_ff <= '0;
      end else begin
         ctrl3_ff <= div_ctrl_ff[DIV_STAGES-1];
      end
      days3_ff <= days_q;
      q7_ff    <= q7_prod[Q7_K +: Q7_W];
   end

   // Stage 4: weekday, and the Thursday of the same ISO week
   always_comb begin
      rem7_full = days3_ff - DAYS_W'(q7_ff) * DAYS_W'(DAYS_PER_WEEK);
      rem7      = rem7_full[2:0];
      iso_dow   = iso_of_rem(rem7);
      thu_in    = days3_ff + DAYS_W'(THURSDAY_ISO) - DAYS_W'(iso_dow);
      ctrl4_in  = ctrl3_ff;
      ctrl4_in.dow = dow_of_rem(rem7);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl4_ff <= '0;
      end else begin
         ctrl4_ff <= ctrl4_in;
      end
      days4_ff <= days3_ff;
      thu4_ff  <= thu_in;
   end

   // Two converters side by side: the date itself and its week's Thursday
   tsc_civil u_civ_date (
      .clock   (clock),
      .day_num (days4_ff),
      .civil   (civ_date)
   );

   tsc_civil u_civ_thu (
      .clock   (clock),
      .day_num (thu4_ff),
      .civil   (civ_thu)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CIV_STAGES; k++) begin
            civ_ctrl_ff[k] <= '0;
         end
      end else begin
         civ_ctrl_ff[0] <= ctrl4_ff;
         for (int k = 1; k < CIV_STAGES; k++) begin
            civ_ctrl_ff[k] <= civ_ctrl_ff[k-1];
         end
      end
   end

   assign ctrl_out = civ_ctrl_ff[CIV_STAGES-1];

   // Stage 5: ISO week from the Thursday's day of year; zero the fields out of range
   assign wk_prod = WK_P_W'(civ_thu.ordinal) * WK_P_W'(WK_MUL);
   assign week_in = wk_prod[WK_K +: WEEK_W] + WEEK_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctrl_out.valid;
      end
      range_err_ff <= ctrl_out.range_err;
      if (ctrl_out.range_err) begin
         year_ff  <= '0;
         month_ff <= '0;
         dom_ff   <= '0;
         dow_ff   <= '0;
         week_ff  <= '0;
      end else begin
         year_ff  <= civ_date.year;
         month_ff <= civ_date.month;
         dom_ff   <= civ_date.day;
         dow_ff   <= ctrl_out.dow;
         week_ff  <= week_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_year_value   = year_ff;
   assign rsp_month_value  = month_ff;
   assign rsp_day_of_month = dom_ff;
   assign rsp_weekday      = dow_ff;
   assign rsp_iso_week     = week_ff;
   assign rsp_range_error  = range_err_ff;

endmodule

>>> tb/calendar_fields_checker.sv
`timescale 1ns / 1ps

module calendar_fields_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic                              busy,
   input  logic [tsc_pkg::TS_W-1:0]          req_timestamp_ms,
   input  logic                              csr_wr_en,
   input  logic signed [tsc_pkg::TZ_W-1:0]   csr_wr_data,
   input  logic                              rsp_valid,
   input  logic [tsc_pkg::YEAR_W-1:0]        rsp_year_value,
   input  logic [tsc_pkg::MONTH_W-1:0]       rsp_month_value,
   input  logic [tsc_pkg::DOM_W-1:0]         rsp_day_of_month,
   input  logic [tsc_pkg::DOW_W-1:0]         rsp_weekday,
   input  logic [tsc_pkg::WEEK_W-1:0]        rsp_iso_week,
   input  logic                              rsp_range_error,
   output int                                mismatch_total,
   output int                                dates_pending,
   output int                                dates_checked,
   output int                                range_flags
);
   import tsc_pkg::*;

   localparam longint LAST_SECOND = 64'sd253402300799;
   localparam longint MS_PER_DAY  = 64'sd86400000;
   localparam int     PRINT_CAP   = 40;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DOM_W-1:0]   mday;
      logic [DOW_W-1:0]   weekday;
      logic [WEEK_W-1:0]  week;
      logic               range_error;
   } calendar_type;

   calendar_type            expected_dates[$];
   logic signed [TZ_W-1:0]  tz_hours;
   int                      mismatches = 0;

   assign mismatch_total = mismatches;

   // Day count since 1970-01-01 to a proleptic Gregorian date
   function automatic void date_of_day(input longint dn, output longint y,
                                       output longint m, output longint d);
      longint z, era, doe, yoe, doy, mp;
      z   = dn + 719468;
      era = (z >= 0 ? z : z - 146096) / 146097;
      doe = z - era * 146097;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp  = (5 * doy + 2) / 153;
      d   = doy - (153 * mp + 2) / 5 + 1;
      m   = (mp < 10) ? mp + 3 : mp - 9;
      y   = yoe + era * 400 + ((m <= 2) ? 1 : 0);
   endfunction

   // Day count of January 1st of a year (1969 had 477 leap days behind it)
   function automatic longint first_day_of_year(input longint y);
      return 365 * (y - 1970) + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400 - 477;
   endfunction

   function automatic calendar_type predict_calendar(input logic [TS_W-1:0] stamp,
                                                     input logic signed [TZ_W-1:0] tz);
      calendar_type f;
      longint    local_ms, day_num, y, m, d, iso_dow, thu_day, ty, tm, td;
      f        = '0;
      local_ms = longint'(stamp) + longint'(tz) * 64'sd3600000;
      if (local_ms < 0 || local_ms / 1000 > LAST_SECOND) begin
         f.range_error = 1'b1;
         return f;
      end
      day_num = local_ms / MS_PER_DAY;
      date_of_day(day_num, y, m, d);
      // epoch day was a Thursday
      iso_dow = (day_num + 3) % 7 + 1;
      thu_day = day_num - iso_dow + 4;
      date_of_day(thu_day, ty, tm, td);
      f.year    = YEAR_W'(y);
      f.month   = MONTH_W'(m);
      f.mday    = DOM_W'(d);
      f.weekday = DOW_W'((day_num + 4) % 7 + 1);
      f.week    = WEEK_W'((thu_day - first_day_of_year(ty)) / 7 + 1);
      return f;
   endfunction

   task automatic flag_mismatch(input string what, input longint got, input longint want);
      if (mismatches < PRINT_CAP)
         $display("[%0t] MISMATCH %s: got %0d, want %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      calendar_type want;
      if (reset) begin
         expected_dates.delete();
         tz_hours = TZ_RESET;
      end else begin
         if (rsp_valid) begin
            if (expected_dates.size() == 0) begin
               flag_mismatch("result with no transaction pending", rsp_year_value, 0);
            end else begin
               want = expected_dates.pop_front();
               if (rsp_year_value !== want.year)
                  flag_mismatch("year_value", rsp_year_value, want.year);
               if (rsp_month_value !== want.month)
                  flag_mismatch("month_value", rsp_month_value, want.month);
               if (rsp_day_of_month !== want.mday)
                  flag_mismatch("day_of_month", rsp_day_of_month, want.mday);
               if (rsp_weekday !== want.weekday)
                  flag_mismatch("weekday", rsp_weekday, want.weekday);
               if (rsp_iso_week !== want.week)
                  flag_mismatch("iso_week", rsp_iso_week, want.week);
               if (rsp_range_error !== want.range_error)
                  flag_mismatch("range_error", rsp_range_error, want.range_error);
               dates_checked <= dates_checked + 1;
               if (want.range_error)
                  range_flags <= range_flags + 1;
            end
         end
         if (start && !busy)
            expected_dates.push_back(predict_calendar(req_timestamp_ms, tz_hours));
         // offset is only written while the pipeline is empty
         if (csr_wr_en)
            tz_hours = csr_wr_data;
      end
      dates_pending <= expected_dates.size();
   end

   initial begin
      dates_pending = 0;
      dates_checked = 0;
      range_flags   = 0;
   end

endmodule

>>> tb/timestamp_to_calendar_fields_tb.sv
`timescale 1ns / 1ps

module timestamp_to_calendar_fields_tb;
   import tsc_pkg::*;

   // Cycles with no transaction on either side before the run is abandoned
   localparam int     STALL_LIMIT   = 2000;
   // Allow some slack when flushing at the end
   localparam int     FLUSH_CYCLES  = 40;
   localparam int     PHASES        = 9;
   localparam int     RANDOM_ITEMS  = 105;
   localparam longint MS_PER_DAY    = 64'sd86400000;
   localparam longint MS_PER_HR     = 64'sd3600000;
   localparam longint FIRST_BAD_MS  = 64'sd253402300800000;
   localparam longint VALID_SPAN_MS = 64'sd253402300800000;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [TS_W-1:0]          req_timestamp_ms;
   logic                     csr_wr_en;
   logic signed [TZ_W-1:0]   csr_wr_data;
   logic                     rsp_valid;
   logic [YEAR_W-1:0]        rsp_year_value;
   logic [MONTH_W-1:0]       rsp_month_value;
   logic [DOM_W-1:0]         rsp_day_of_month;
   logic [DOW_W-1:0]         rsp_weekday;
   logic [WEEK_W-1:0]        rsp_iso_week;
   logic                     rsp_range_error;

   int mismatch_total;
   int dates_pending;
   int dates_checked;
   int range_flags;

   int tz_now;
   int idle_pct;
   int stamps_sent;
   int idle_run;

   // 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   timestamp_to_calendar_fields dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_timestamp_ms (req_timestamp_ms),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_year_value   (rsp_year_value),
      .rsp_month_value  (rsp_month_value),
      .rsp_day_of_month (rsp_day_of_month),
      .rsp_weekday      (rsp_weekday),
      .rsp_iso_week     (rsp_iso_week),
      .rsp_range_error  (rsp_range_error)
   );

   calendar_fields_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_timestamp_ms (req_timestamp_ms),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_year_value   (rsp_year_value),
      .rsp_month_value  (rsp_month_value),
      .rsp_day_of_month (rsp_day_of_month),
      .rsp_weekday      (rsp_weekday),
      .rsp_iso_week     (rsp_iso_week),
      .rsp_range_error  (rsp_range_error),
      .mismatch_total   (mismatch_total),
      .dates_pending    (dates_pending),
      .dates_checked    (dates_checked),
      .range_flags      (range_flags)
   );

   // Watchdog: restart the count on any accepted transaction, either side
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_run <= 0;
      end else begin
         idle_run <= idle_run + 1;
         if (idle_run >= STALL_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Day number (days since 1970-01-01) of a civil date, used to aim stimulus;
   // day values past the month end simply roll into the next month
   function automatic longint civil_day(input int y, input int m, input int d);
      int  month_start [12];
      bit  leap;
      month_start = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
      leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      return 365 * longint'(y - 1970) + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400 - 477
             + month_start[m - 1] + ((leap && m > 2) ? 1 : 0) + d - 1;
   endfunction

   // Present one transaction; idle first at the current rate, then hold start
   // high until the block takes it. Leave start high so back-to-back
   // transactions need no extra edge.
   task automatic send_stamp(input longint ms);
      if (ms < 0)
         ms = 0;
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start            <= 1'b1;
      req_timestamp_ms <= ms[TS_W-1:0];
      do @(posedge clock); while (busy);
      stamps_sent++;
   endtask

   // Aim a transaction at a local civil date and time of day (ms)
   task automatic send_date(input int y, input int m, input int d, input longint ms_of_day);
      send_stamp(civil_day(y, m, d) * MS_PER_DAY + ms_of_day - tz_now * MS_PER_HR);
   endtask

   // Drop start and wait until every transaction in flight has come back
   task automatic drain;
      @(negedge clock);
      start <= 1'b0;
      do @(posedge clock); while (dates_pending != 0);
   endtask

   task automatic write_offset(input int hours);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= TZ_W'(hours);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      tz_now = hours;
   endtask

   // Random transaction: mostly in-range dates aimed at the interesting spots
   // (year turns, month ends, leap days, both range edges), some raw noise
   task automatic send_random_stamp;
      int     pick;
      int     y;
      longint ms;
      logic [TS_W-1:0] raw;
      pick = $urandom_range(99);
      raw  = {16'($urandom()), 32'($urandom())};
      if (pick < 35) begin
         ms = longint'(raw) % VALID_SPAN_MS;
      end else if (pick < 50) begin
         // around a new year: ISO week 1 / 52 / 53 transitions
         y  = $urandom_range(1970, 9999);
         ms = (civil_day(y, 1, 1) + $urandom_range(20) - 10) * MS_PER_DAY
              + $urandom_range(86399999) - tz_now * MS_PER_HR;
      end else if (pick < 60) begin
         y  = $urandom_range(1970, 9999);
         ms = civil_day(y, $urandom_range(1, 12), $urandom_range(28, 32)) * MS_PER_DAY
              + $urandom_range(86399999) - tz_now * MS_PER_HR;
      end else if (pick < 70) begin
         // adjusted time close to zero: negative side gives a range flag
         ms = -tz_now * MS_PER_HR
              + (($urandom_range(1)) ? $urandom_range(6) - 3 : $urandom_range(4000) - 2000);
      end else if (pick < 80) begin
         // adjusted time close to the end of year 9999
         ms = FIRST_BAD_MS - tz_now * MS_PER_HR
              + (($urandom_range(1)) ? $urandom_range(6) - 3 : $urandom_range(4000) - 2000);
      end else if (pick < 90) begin
         ms = longint'(raw);
      end else begin
         // leap February: Feb 27 and the three days after it, in a multiple of four (centuries too)
         y  = 4 * $urandom_range(493, 2499);
         ms = (civil_day(y, 2, 27) + $urandom_range(3)) * MS_PER_DAY
              + $urandom_range(86399999) - tz_now * MS_PER_HR;
      end
      send_stamp(ms);
   endtask

   initial begin
      int offset_plan [PHASES];
      int phase;

      reset            = 1'b1;
      start            = 1'b0;
      req_timestamp_ms = '0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      idle_run         = 0;
      stamps_sent      = 0;
      tz_now           = 8;

      // Reset value first, then the extremes of the 5-bit field (also the
      // values outside -12..14), a random setting and a few ordinary ones
      offset_plan    = '{8, -16, 15, -12, 14, 0, -13, 0, -1};
      offset_plan[7] = int'($urandom_range(31)) - 16;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (phase = 0; phase < PHASES; phase++) begin
         // sender idles 27 %, then 80 %, then runs flat out
         idle_pct = (phase < 3) ? 27 : (phase < 6) ? 80 : 0;
         if (phase == 0) begin
            // Directed: offset still at its reset value of +8 hours
            send_stamp(0);
            send_stamp(64'sh0000_FFFF_FFFF_FFFF);
            send_stamp(64'sd253402300799999);
            send_date(9999, 12, 31, 86399999);   // last valid millisecond
            send_date(10000, 1, 1, 0);           // first one past it
            send_date(9999, 1, 1, 0);
            send_date(1970, 1, 4, 0);            // first Sunday, ISO week 1
            send_date(1970, 1, 5, 0);            // Monday, ISO week 2
            send_date(2000, 2, 29, 86399999);
            send_date(2000, 3, 1, 0);
            send_date(2100, 2, 28, 43200000);
            send_date(2100, 3, 1, 999);          // truncation of the millis
            send_date(2016, 1, 1, 3600000);      // week 53 of previous year
            send_date(2018, 12, 31, 0);          // week 1 of next year
            send_date(2020, 12, 31, 0);          // week 53
            send_date(2021, 1, 3, 86399999);     // still week 53
            send_date(2021, 1, 4, 0);            // week 1
            send_date(2023, 4, 30, 7200001);
            send_date(2024, 12, 31, 1);
            send_date(2026, 1, 1, 0);
         end else begin
            // reconfigure only with the pipeline empty
            drain();
            write_offset(offset_plan[phase]);
         end
         repeat (RANDOM_ITEMS) send_random_stamp();
      end

      drain();
      repeat (FLUSH_CYCLES) @(posedge clock);

      $display("Run covered %0d timestamps over %0d offset settings (-16..+15 hours).",
               stamps_sent, PHASES);
      $display("Checked %0d results, %0d of them out of range; %0d field mismatches.",
               dates_checked, range_flags, mismatch_total);
      if (mismatch_total == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
